// ----- design/dpq_pkg.sv -----
package dpq_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int CMD_W        = 2;
	localparam int CLIENT_W     = 31;
	localparam int PRIO_W       = 32;
	localparam int COUNT_W      = 16;
	localparam int STATUS_W     = 2;
	localparam int OR_RADIX_LOG = 5;
	localparam int OR_RADIX     = 1 << OR_RADIX_LOG;
	localparam int IN_DATA_W    = 72;
	localparam int OUT_DATA_W   = 40;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT  = 2'd0,
		CMD_POP_MAX = 2'd1,
		CMD_POP_MIN = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 2'd0,
		ST_POPPED   = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_INSERT,
		OP_DUP,
		OP_POPMIN_DEC,
		OP_POPMIN_SHIFT,
		OP_POPMAX
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_APPLY
	} state_t;

	// what a cell shows its neighbors and the top level
	typedef struct packed {
		logic                       valid;
		logic signed [PRIO_W-1:0]   prio;
		logic [CLIENT_W-1:0]        client;
		logic [COUNT_W-1:0]         count;
		logic                       lt;
		logic                       eq;
	} cell_t;

	// broadcast to every cell
	typedef struct packed {
		op_t                        op;
		logic signed [PRIO_W-1:0]   key;
		logic [CLIENT_W-1:0]        client;
	} cell_ctl_t;

	localparam cell_t CELL_LEFT_END  = '{lt: 1'b1, default: '0};
	localparam cell_t CELL_RIGHT_END = '{default: '0};

	// registered levels of a radix-32 or tree over n leaves
	function automatic int tree_levels(input int n);
		int levels;
		levels = 0;
		for (int l = 0; l < 4; l++) begin
			if ((1 << (OR_RADIX_LOG * l)) < n) begin
				levels++;
			end
		end
		if (levels == 0) begin
			levels = 1;
		end
		return levels;
	endfunction

	// number of nodes at tree level l
	function automatic int level_width(input int n, input int l);
		return (n + (1 << (OR_RADIX_LOG * l)) - 1) >> (OR_RADIX_LOG * l);
	endfunction

endpackage

// ----- design/dpq_cell.sv -----
module dpq_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  dpq_pkg::cell_ctl_t ctl,
	input  dpq_pkg::cell_t    left,
	input  dpq_pkg::cell_t    right,
	output dpq_pkg::cell_t    q
);
	import dpq_pkg::*;

	logic                     valid_q;
	logic signed [PRIO_W-1:0] prio_q;
	logic [CLIENT_W-1:0]      client_q;
	logic [COUNT_W-1:0]       count_q;
	logic                     lt;
	logic                     eq;
	logic                     valid_d;
	logic signed [PRIO_W-1:0] prio_d;
	logic [CLIENT_W-1:0]      client_d;
	logic [COUNT_W-1:0]       count_d;

	assign lt = valid_q && (prio_q < ctl.key);
	assign eq = valid_q && (prio_q == ctl.key);

	assign q = '{valid: valid_q, prio: prio_q, client: client_q, count: count_q,
		lt: lt, eq: eq};

	always_comb begin
		valid_d  = valid_q;
		prio_d   = prio_q;
		client_d = client_q;
		count_d  = count_q;
		unique case (ctl.op)
			OP_INSERT: begin
				if (left.lt && !lt) begin
					valid_d  = 1'b1;
					prio_d   = ctl.key;
					client_d = ctl.client;
					count_d  = COUNT_W'(1);
				end else if (!left.lt && !lt) begin
					valid_d  = left.valid;
					prio_d   = left.prio;
					client_d = left.client;
					count_d  = left.count;
				end
			end
			OP_DUP: begin
				if (eq && count_q != COUNT_MAX) begin
					count_d = count_q + COUNT_W'(1);
				end
			end
			OP_POPMIN_DEC: begin
				// only the lowest entry has no valid left neighbor
				if (valid_q && !left.valid) begin
					count_d = count_q - COUNT_W'(1);
				end
			end
			OP_POPMIN_SHIFT: begin
				valid_d  = right.valid;
				prio_d   = right.prio;
				client_d = right.client;
				count_d  = right.count;
			end
			OP_POPMAX: begin
				if (valid_q && !right.valid) begin
					if (count_q > COUNT_W'(1)) begin
						count_d = count_q - COUNT_W'(1);
					end else begin
						valid_d = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		prio_q   <= prio_d;
		client_q <= client_d;
		count_q  <= count_d;
	end

endmodule

// ----- design/dpq_or_tree.sv -----
module dpq_or_tree #(
	parameter int N  = dpq_pkg::CAPACITY_DEF,
	parameter int DW = 1
) (
	input  logic          clk,
	input  logic [DW-1:0] din [N],
	output logic [DW-1:0] dout
);
	import dpq_pkg::*;

	localparam int LEVELS = tree_levels(N);

	logic [DW-1:0] lvl_q [1:LEVELS][N];
	logic [DW-1:0] lvl_d [1:LEVELS][N];

	// each node ors up to 32 nodes of the level below
	always_comb begin
		for (int l = 1; l <= LEVELS; l++) begin
			for (int j = 0; j < N; j++) begin
				lvl_d[l][j] = '0;
				if (j < level_width(N, l)) begin
					for (int k = 0; k < OR_RADIX; k++) begin
						if (j * OR_RADIX + k < level_width(N, l - 1)) begin
							if (l == 1) begin
								lvl_d[l][j] = lvl_d[l][j] | din[j * OR_RADIX + k];
							end else begin
								lvl_d[l][j] = lvl_d[l][j] | lvl_q[l - 1][j * OR_RADIX + k];
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		lvl_q <= lvl_d;
	end

	assign dout = lvl_q[LEVELS][0];

endmodule

// ----- design/double_ended_priority_queue_core.sv -----
// double-ended priority queue: a sorted row of CAPACITY cells, lowest priority
// in cell 0, each cell holding one distinct priority with its client id and a
// 16-bit duplicate count. a beat on s_ carries one command (insert, pop highest,
// pop lowest) and produces exactly one beat on m_ with a status and the popped
// client. inserting a priority already present bumps its count (saturating) and
// keeps the stored client; a new priority into a full row is dropped with status
// full; a pop on an empty row returns status empty with client 0; cmd 3 is a
// no-op with status inserted. one command is in flight at a time: the next
// command is taken only after the current one has been applied, and the apply
// is held back while an earlier result still waits on m_tready. every cell
// compares the key in parallel, then a registered radix-32 or tree of L levels,
// L = ceil(log32(CAPACITY)) (2 at the default 1024), finds a duplicate and the
// client of the top entry, and the apply state does the shift/update across
// the row. the result register lets a new command be taken while the last
// result waits on m_tready.
// reset clears only the valid bit of each cell, no clearing pass is needed.
module double_ended_priority_queue_core #(
	parameter int CAPACITY = dpq_pkg::CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// cmd [1:0], client [32:2], priority_req [64:33], zero fill [71:65]
	input  logic [dpq_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// status [1:0], popped_client [32:2], zero fill [39:33]
	output logic [dpq_pkg::OUT_DATA_W-1:0]   m_tdata
);
	import dpq_pkg::*;

	localparam int LEVELS = tree_levels(CAPACITY);
	localparam int CNT_W  = $clog2(LEVELS + 1);

	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         cnt_q, cnt_d;

	// command register
	cmd_t                     cmd_q;
	logic [CLIENT_W-1:0]      client_q;
	logic signed [PRIO_W-1:0] key_q;

	// result register
	logic                     out_vld_q;
	status_t                  out_status_q;
	logic [CLIENT_W-1:0]      out_client_q;

	logic                     s_beat;
	logic                     apply_go;
	op_t                      op;
	status_t                  status_d;
	logic [CLIENT_W-1:0]      popped_d;

	cell_ctl_t                ctl;
	cell_t                    cell_o [CAPACITY];
	logic [CAPACITY-1:0]      cell_vld;
	logic [0:0]               eq_leaf [CAPACITY];
	logic [CLIENT_W-1:0]      top_leaf [CAPACITY];
	logic [0:0]               dup_hit;
	logic [CLIENT_W-1:0]      top_client;
	logic                     empty;
	logic                     full;

	assign s_beat = s_tvalid && s_tready;

	// ---------------------------------------------------------------- cell row
	assign ctl = '{op: op, key: key_q, client: client_q};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_t left_in;
		cell_t right_in;

		if (i == 0) begin : g_first
			assign left_in = CELL_LEFT_END;
		end else begin : g_mid_l
			assign left_in = cell_o[i - 1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_in = CELL_RIGHT_END;
			assign top_leaf[i] = cell_o[i].valid ? cell_o[i].client : '0;
		end else begin : g_mid_r
			assign right_in = cell_o[i + 1];
			assign top_leaf[i] = (cell_o[i].valid && !cell_o[i + 1].valid) ?
				cell_o[i].client : '0;
		end

		assign cell_vld[i] = cell_o[i].valid;
		assign eq_leaf[i]  = cell_o[i].eq;

		dpq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.left   (left_in),
			.right  (right_in),
			.q      (cell_o[i])
		);
	end

	// live cells are always packed from cell 0 up
	assign empty = !cell_vld[0];
	assign full  = cell_vld[CAPACITY - 1];

	// ---------------------------------------------------------------- search trees
	// duplicate key anywhere in the row
	dpq_or_tree #(
		.N  (CAPACITY),
		.DW (1)
	) u_dup_tree (
		.clk  (clk),
		.din  (eq_leaf),
		.dout (dup_hit)
	);

	// client of the highest live entry (only that leaf is nonzero)
	dpq_or_tree #(
		.N  (CAPACITY),
		.DW (CLIENT_W)
	) u_top_tree (
		.clk  (clk),
		.din  (top_leaf),
		.dout (top_client)
	);

	// ---------------------------------------------------------------- control
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		s_tready = 1'b0;
		apply_go = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = S_SEARCH;
					cnt_d   = '0;
				end
			end
			S_SEARCH: begin
				// stay here until the trees have settled, with the key held still
				if (cnt_q == CNT_W'(LEVELS - 1)) begin
					state_d = S_APPLY;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			S_APPLY: begin
				if (!out_vld_q || m_tready) begin
					apply_go = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// row operation and result of the current command
	always_comb begin
		op       = OP_NONE;
		status_d = ST_INSERTED;
		popped_d = '0;
		unique case (cmd_q)
			CMD_INSERT: begin
				if (dup_hit[0]) begin
					op = OP_DUP;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					op = OP_INSERT;
				end
			end
			CMD_POP_MAX: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					status_d = ST_POPPED;
					popped_d = top_client;
					op       = OP_POPMAX;
				end
			end
			CMD_POP_MIN: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					status_d = ST_POPPED;
					popped_d = cell_o[0].client;
					op       = (cell_o[0].count > COUNT_W'(1)) ? OP_POPMIN_DEC :
						OP_POPMIN_SHIFT;
				end
			end
			CMD_NOP: begin
			end
			default: begin
			end
		endcase
		if (!apply_go) begin
			op = OP_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (apply_go) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_beat) begin
			cmd_q    <= cmd_t'(s_tdata[CMD_W-1:0]);
			client_q <= s_tdata[CMD_W +: CLIENT_W];
			key_q    <= $signed(s_tdata[CMD_W + CLIENT_W +: PRIO_W]);
		end
		if (apply_go) begin
			out_status_q <= status_d;
			out_client_q <= popped_d;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {(OUT_DATA_W - STATUS_W - CLIENT_W)'(0), out_client_q, out_status_q};

	// ---------------------------------------------------------------- checks
	// input is taken only between commands
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready)
		else $error("input ready while a command is in flight");

	// live cells form one run starting at cell 0
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_vld & (cell_vld + 1'b1)) == '0))
		else $error("live cells not packed from the low end");

	// a new entry grows the row by exactly one
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_INSERT) |=> ($countones(cell_vld) == $past($countones(cell_vld)) + 1))
		else $error("insert did not add one entry");

	// a pop on an empty row reports empty
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(apply_go && empty && (cmd_q == CMD_POP_MAX || cmd_q == CMD_POP_MIN))
		|=> (m_tvalid && out_status_q == ST_EMPTY && out_client_q == '0))
		else $error("empty pop not reported");

	// a removal by pop-min shifts the row down and leaves one entry fewer
	a_popmin_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_POPMIN_SHIFT) |=> ($countones(cell_vld) + 1 == $past($countones(cell_vld))))
		else $error("pop lowest did not remove one entry");

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
	import dpq_pkg::*;

	localparam int CAP         = CAPACITY_DEF;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int RANDOM_CMDS = 150;
	localparam int MAX_SHOWN   = 10;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	double_ended_priority_queue_core #(
		.CAPACITY(CAP)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #4 clk = ~clk;

	// one queue entry as the bench keeps it, ascending by signed priority
	typedef struct {
		logic signed [PRIO_W-1:0] prio;
		logic [CLIENT_W-1:0]      client;
		logic [COUNT_W-1:0]       count;
	} slot_t;

	typedef struct {
		status_t             status;
		logic [CLIENT_W-1:0] client;
	} reply_t;

	typedef struct {
		cmd_t                cmd;
		logic [CLIENT_W-1:0] client;
		logic [PRIO_W-1:0]   prio;
		bit                  typed;
		status_t             status;
		logic [CLIENT_W-1:0] popped;
	} plan_row_t;

	slot_t     sorted_slots[$];
	reply_t    awaited_replies[$];
	plan_row_t plan_rows[20];

	bit          no_idle = 1'b0;
	int unsigned cycle_count = 0;
	int unsigned mismatches = 0;
	int unsigned n_sent = 0;
	int unsigned n_checked = 0;
	int unsigned n_full = 0;
	int unsigned n_empty = 0;
	int unsigned n_popped = 0;
	int unsigned peak_fill = 0;

	status_t             seen_status;
	logic [CLIENT_W-1:0] seen_client;
	reply_t              oldest;

	// mostly back to back, some short gaps, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		if (r < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// next state of the queue and the reply for one accepted command
	function automatic reply_t apply_cmd(input cmd_t cmd, input logic [CLIENT_W-1:0] client,
			input logic signed [PRIO_W-1:0] prio);
		reply_t rep;
		slot_t  fresh;
		int     pos;
		rep.status = ST_INSERTED;
		rep.client = '0;
		case (cmd)
			CMD_INSERT: begin
				pos = 0;
				while (pos < sorted_slots.size() && sorted_slots[pos].prio < prio) begin
					pos++;
				end
				if (pos < sorted_slots.size() && sorted_slots[pos].prio == prio) begin
					// duplicate keeps the stored client, count saturates
					if (sorted_slots[pos].count != COUNT_MAX) begin
						sorted_slots[pos].count++;
					end
				end else if (sorted_slots.size() >= CAP) begin
					rep.status = ST_FULL;
				end else begin
					fresh.prio   = prio;
					fresh.client = client;
					fresh.count  = 1;
					sorted_slots.insert(pos, fresh);
				end
			end
			CMD_POP_MAX, CMD_POP_MIN: begin
				if (sorted_slots.size() == 0) begin
					rep.status = ST_EMPTY;
				end else begin
					pos        = (cmd == CMD_POP_MAX) ? sorted_slots.size() - 1 : 0;
					rep.status = ST_POPPED;
					rep.client = sorted_slots[pos].client;
					if (sorted_slots[pos].count > 1) begin
						sorted_slots[pos].count--;
					end else begin
						sorted_slots.delete(pos);
					end
				end
			end
			default: begin
			end
		endcase
		return rep;
	endfunction

	// send one beat; a typed reply overrides the computed one as the expectation
	task automatic issue(input cmd_t cmd, input logic [CLIENT_W-1:0] client,
			input logic [PRIO_W-1:0] prio, input bit typed, input status_t t_status,
			input logic [CLIENT_W-1:0] t_popped);
		int     gap;
		reply_t rep;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, prio, client, cmd};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		rep = apply_cmd(cmd, client, prio);
		if (typed) begin
			rep.status = t_status;
			rep.client = t_popped;
		end
		awaited_replies.push_back(rep);
		n_sent++;
		if (sorted_slots.size() > peak_fill) begin
			peak_fill = sorted_slots.size();
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= MAX_SHOWN) begin
			$display("mismatch in %s at reply %0d: expected %h, got %h",
				what, n_checked, want, got);
		end
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies still awaited",
				cycle_count, awaited_replies.size());
			$display("FAILURE");
			$finish;
		end
	end

	// reply checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_status = status_t'(m_tdata[1:0]);
			seen_client = m_tdata[32:2];
			if (awaited_replies.size() == 0) begin
				flag_mismatch("unexpected beat", 32'hffffffff, {30'b0, seen_status});
			end else begin
				oldest = awaited_replies.pop_front();
				if (seen_status !== oldest.status) begin
					flag_mismatch("status", {30'b0, oldest.status}, {30'b0, seen_status});
				end
				if (seen_client !== oldest.client) begin
					flag_mismatch("popped client", {1'b0, oldest.client}, {1'b0, seen_client});
				end
				case (seen_status)
					ST_FULL:   n_full++;
					ST_EMPTY:  n_empty++;
					ST_POPPED: n_popped++;
					default:   begin
					end
				endcase
			end
			n_checked++;
		end
	end

	// sink side back-pressure
	initial begin : sink_ready
		int run;
		@(posedge clk);
		forever begin
			m_tready <= 1'b1;
			run = no_idle ? 1 : $urandom_range(1, 12);
			repeat (run) @(posedge clk);
			run = idle_len();
			if (run > 0) begin
				m_tready <= 1'b0;
				repeat (run) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int          order[CAP];
		int          j;
		int          tmp;
		int          ins_weight;
		int          r;
		cmd_t        cmd;
		logic [31:0] prio;

		plan_rows = '{
			'{CMD_POP_MAX, 31'd0,          32'h00000000, 1'b1, ST_EMPTY,    31'd0},
			'{CMD_POP_MIN, 31'd0,          32'h00000000, 1'b1, ST_EMPTY,    31'd0},
			'{CMD_NOP,     31'h7fffffff,   32'hffffffff, 1'b1, ST_INSERTED, 31'd0},
			'{CMD_INSERT,  31'h7fffffff,   32'h7fffffff, 1'b1, ST_INSERTED, 31'd0},
			'{CMD_INSERT,  31'd0,          32'h80000000, 1'b1, ST_INSERTED, 31'd0},
			'{CMD_INSERT,  31'h00012345,   32'h00000000, 1'b1, ST_INSERTED, 31'd0},
			'{CMD_INSERT,  31'h55555555,   32'hffffffff, 1'b1, ST_INSERTED, 31'd0},
			'{CMD_INSERT,  31'h2aaaaaaa,   32'h00000000, 1'b0, ST_INSERTED, 31'd0},
			'{CMD_POP_MAX, 31'd0,          32'h00000000, 1'b1, ST_POPPED,   31'h7fffffff},
			'{CMD_POP_MIN, 31'd0,          32'h00000000, 1'b1, ST_POPPED,   31'd0},
			'{CMD_POP_MIN, 31'd0,          32'h00000000, 1'b0, ST_INSERTED, 31'd0},
			'{CMD_POP_MAX, 31'd0,          32'h00000000, 1'b0, ST_INSERTED, 31'd0},
			'{CMD_POP_MIN, 31'd0,          32'h00000000, 1'b0, ST_INSERTED, 31'd0},
			'{CMD_POP_MAX, 31'd0,          32'h00000000, 1'b1, ST_EMPTY,    31'd0},
			'{CMD_INSERT,  31'd1,          32'h00000001, 1'b0, ST_INSERTED, 31'd0},
			'{CMD_INSERT,  31'd2,          32'hfffffffe, 1'b0, ST_INSERTED, 31'd0},
			'{CMD_NOP,     31'd0,          32'h00000000, 1'b1, ST_INSERTED, 31'd0},
			'{CMD_POP_MIN, 31'd0,          32'h00000000, 1'b0, ST_INSERTED, 31'd0},
			'{CMD_POP_MAX, 31'd0,          32'h00000000, 1'b0, ST_INSERTED, 31'd0},
			'{CMD_POP_MIN, 31'd0,          32'h00000000, 1'b1, ST_EMPTY,    31'd0}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pops, nop, extreme keys, duplicate keeps first client
		foreach (plan_rows[i]) begin
			issue(plan_rows[i].cmd, plan_rows[i].client, plan_rows[i].prio,
				plan_rows[i].typed, plan_rows[i].status, plan_rows[i].popped);
		end

		// hold off until the queue has answered everything
		s_tvalid <= 1'b0;
		while (awaited_replies.size() != 0) begin
			@(posedge clk);
		end

		// fill to capacity in shuffled order, distinct keys spread over the range
		for (int i = 0; i < CAP; i++) begin
			order[i] = i;
		end
		for (int i = CAP - 1; i > 0; i--) begin
			j        = $urandom_range(0, i);
			tmp      = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < CAP; i++) begin
			prio = {order[i][9:0] ^ 10'h200, 22'($urandom)};
			issue(CMD_INSERT, 31'($urandom), prio, 1'b0, ST_INSERTED, '0);
		end
		// new keys into a full queue are dropped, duplicates still count
		repeat (4) begin
			prio = sorted_slots[$urandom_range(0, CAP - 1)].prio ^ 32'h1;
			issue(CMD_INSERT, 31'($urandom), prio, 1'b0, ST_INSERTED, '0);
			prio = sorted_slots[$urandom_range(0, CAP - 1)].prio;
			issue(CMD_INSERT, 31'($urandom), prio, 1'b0, ST_INSERTED, '0);
		end
		issue(CMD_INSERT, 31'h7fffffff, 32'h7fffffff, 1'b0, ST_INSERTED, '0);
		issue(CMD_INSERT, 31'h0, 32'h80000000, 1'b0, ST_INSERTED, '0);
		issue(CMD_NOP, 31'($urandom), $urandom, 1'b0, ST_INSERTED, '0);

		// random mix on the full queue, insert weight shifts between drain and refill
		ins_weight = 50;
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			if (n % 100 == 0) begin
				ins_weight = 30 + 20 * $urandom_range(0, 2);
				no_idle    = ($urandom_range(0, 3) == 0);
			end
			r = $urandom_range(0, 99);
			if (r < ins_weight) begin
				cmd = CMD_INSERT;
			end else if (r < 97) begin
				cmd = $urandom_range(0, 1) ? CMD_POP_MAX : CMD_POP_MIN;
			end else begin
				cmd = CMD_NOP;
			end
			r = $urandom_range(0, 9);
			if (r < 6) begin
				prio = 32'($signed($urandom_range(0, 15)) - 8);
			end else if (r < 8) begin
				case ($urandom_range(0, 3))
					0:       prio = 32'h7fffffff;
					1:       prio = 32'h80000000;
					2:       prio = 32'h0;
					default: prio = 32'hffffffff;
				endcase
			end else begin
				prio = $urandom;
			end
			issue(cmd, 31'($urandom), prio, 1'b0, ST_INSERTED, '0);
		end
		s_tvalid <= 1'b0;
		no_idle = 1'b0;

		while (awaited_replies.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);

		$display("run covered %0d commands, %0d replies checked, peak fill %0d of %0d",
			n_sent, n_checked, peak_fill, CAP);
		$display("replies seen: %0d popped, %0d empty, %0d full; %0d mismatches",
			n_popped, n_empty, n_full, mismatches);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
